// ----- design/bfra_pkg.sv -----
// Shared types and constants for the bitmap free-run allocator.
package bfra_pkg;

    localparam int CFG_W = 10;   // bytes_in_use register width
    localparam int IDX_W = 12;   // bit_index / position width
    localparam int RUN_W = 13;   // run_length width, also bit-limit width

    typedef logic [1:0] op_t;

    localparam op_t OP_CLEAR = 2'd0;
    localparam op_t OP_TEST  = 2'd1;
    localparam op_t OP_SET   = 2'd2;
    localparam op_t OP_SCAN  = 2'd3;

    typedef struct packed {
        logic start;       // clear run count and hit flag
        logic byte_valid;  // byte_data / byte_addr hold a fresh store byte
    } scan_ctl_t;

    typedef struct packed {
        logic             hit;
        logic [IDX_W-1:0] position;
    } scan_stat_t;

endpackage

// ----- design/bfra_ram.sv -----
// Byte-wide simple dual-port bitmap store, registered read data.
module bfra_ram #(
    parameter int DEPTH  = 512,
    parameter int ADDR_W = 9
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [7:0]        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [7:0]        rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/bfra_run_scan.sv -----
// First-fit free-run detector, consumes one store byte per cycle while byte_valid is set.
module bfra_run_scan
    import bfra_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  scan_ctl_t        ctl,
    input  logic [7:0]       byte_data,
    input  logic [CFG_W-1:0] byte_addr,
    input  logic [RUN_W-1:0] want,
    output scan_stat_t       stat
);

    logic [RUN_W-1:0] run_reg,  run_next;
    logic             hit_reg,  hit_next;
    logic [IDX_W-1:0] pos_reg,  pos_next;

    always_comb
    begin
        logic [RUN_W-1:0] run;
        logic             hit;
        logic [RUN_W-1:0] pos;
        logic [RUN_W-1:0] base;
        run  = run_reg;
        hit  = hit_reg;
        pos  = {1'b0, pos_reg};
        base = {byte_addr, 3'b000};
        if (ctl.byte_valid && !hit_reg)
        begin
            // walk the eight bits, LSB is the lowest bit position
            for (int j = 0; j < 8; j++)
            begin
                if (!hit)
                begin
                    if (byte_data[j])
                        run = '0;
                    else
                        run = run + RUN_W'(1);
                    if (run == want)
                    begin
                        hit = 1'b1;
                        pos = base + RUN_W'(j) + RUN_W'(1) - want;
                    end
                end
            end
        end
        run_next = run;
        hit_next = hit;
        pos_next = pos[IDX_W-1:0];
        if (ctl.start)
        begin
            run_next = '0;
            hit_next = 1'b0;
            pos_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= '0;
            hit_reg <= 1'b0;
            pos_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            hit_reg <= hit_next;
            pos_reg <= pos_next;
        end
    end

    assign stat.hit      = hit_reg;
    assign stat.position = pos_reg;

endmodule

// ----- design/bitmap_free_run_allocator_top.sv -----
// Bitmap allocator top: request sequencer around the byte store and run scanner.
//
//  channel  dir  handshake          payload
//  cfg      in   cfg_valid/ready    cfg_data[9:0] = bytes_in_use
//  s        in   s_tvalid/tready    s_tuser = op, s_tdata = bit_index, set_value, run_length
//  m        out  m_tvalid/tready    m_tdata = found, position, bit_state
//
// After reset the store is zeroed one byte per cycle, all MAX_BYTES entries; s_tready is low.
// Test and set with an index in range do a store read, a modify/write and a response.
// Clear does one store write per byte of bytes_in_use.
// Scan reads one byte per cycle over bytes_in_use bytes and stops early on a hit.
// A finished result sits in the output register; a new request is taken while it waits,
// and the sequencer holds its next result until that register drains.
module bitmap_free_run_allocator_top
    import bfra_pkg::*;
#(
    parameter int MAX_BYTES = 512
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [31:0]      s_tdata,   // [11:0] bit_index, [12] set_value, [25:13] run_length
    input  logic [1:0]       s_tuser,   // [1:0] op
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [15:0]      m_tdata    // [0] found, [12:1] position, [13] bit_state
);

    localparam int AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int SW = $clog2(MAX_BYTES + 1);
    localparam int RESET_BYTES = (512 > MAX_BYTES) ? MAX_BYTES : 512;
    localparam logic [13:0] MAX_BYTES_W = 14'(MAX_BYTES);
    localparam logic [SW-1:0] LAST_ENTRY = SW'(MAX_BYTES - 1);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_RMW,
        ST_SCAN,
        ST_RESP
    } state_t;

    // configuration
    logic [CFG_W-1:0] bytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg <= CFG_W'(RESET_BYTES);
        end
        else if (cfg_valid)
        begin
            if ({4'b0000, cfg_data} > MAX_BYTES_W)
                bytes_reg <= CFG_W'(MAX_BYTES);
            else
                bytes_reg <= cfg_data;
        end
    end

    assign cfg_ready = 1'b1;

    // request fields
    op_t              in_op;
    logic [IDX_W-1:0] in_idx;
    logic             in_val;
    logic [RUN_W-1:0] in_want;

    assign in_op   = s_tuser;
    assign in_idx  = s_tdata[11:0];
    assign in_val  = s_tdata[12];
    assign in_want = s_tdata[25:13];

    logic [SW-1:0]    nbytes;
    logic [RUN_W-1:0] limit;

    assign nbytes = SW'(bytes_reg);
    assign limit  = {bytes_reg, 3'b000};

    state_t           state_reg,  state_next;
    logic [SW-1:0]    cnt_reg,    cnt_next;
    logic [SW-1:0]    dbyte_reg,  dbyte_next;
    logic             dv_reg,     dv_next;
    op_t              op_reg,     op_next;
    logic [IDX_W-1:0] idx_reg,    idx_next;
    logic             val_reg,    val_next;
    logic [RUN_W-1:0] want_reg,   want_next;
    logic             rfound_reg, rfound_next;
    logic [IDX_W-1:0] rpos_reg,   rpos_next;
    logic             rbit_reg,   rbit_next;
    logic             ovalid_reg, ovalid_next;
    logic [15:0]      odata_reg,  odata_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    scan_ctl_t  sc_ctl;
    scan_stat_t sc_stat;

    always_comb
    begin
        logic [7:0] mask;
        mask        = 8'(1) << idx_reg[2:0];
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        dbyte_next  = cnt_reg;
        dv_next     = 1'b0;
        op_next     = op_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        want_next   = want_reg;
        rfound_next = rfound_reg;
        rpos_next   = rpos_reg;
        rbit_next   = rbit_reg;
        ovalid_next = ovalid_reg && !m_tready;
        odata_next  = odata_reg;
        ram_we      = 1'b0;
        ram_waddr   = cnt_reg[AW-1:0];
        ram_wdata   = 8'h00;
        ram_re      = 1'b0;
        ram_raddr   = cnt_reg[AW-1:0];
        sc_ctl      = '0;

        case (state_reg)
            ST_INIT:
            begin
                ram_we = 1'b1;
                if (cnt_reg == LAST_ENTRY)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + SW'(1);
                end
            end

            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next     = in_op;
                    idx_next    = in_idx;
                    val_next    = in_val;
                    want_next   = in_want;
                    cnt_next    = '0;
                    rfound_next = 1'b1;
                    rpos_next   = '0;
                    rbit_next   = 1'b0;
                    case (in_op)
                        OP_CLEAR:
                        begin
                            state_next = (nbytes == '0) ? ST_RESP : ST_CLEAR;
                        end
                        OP_TEST, OP_SET:
                        begin
                            if ({1'b0, in_idx} < limit)
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = AW'(in_idx[11:3]);
                                state_next = ST_RMW;
                            end
                            else
                            begin
                                state_next = ST_RESP;
                            end
                        end
                        OP_SCAN:
                        begin
                            sc_ctl.start = 1'b1;
                            if (in_want != '0 && in_want <= limit)
                            begin
                                state_next = ST_SCAN;
                            end
                            else
                            begin
                                rfound_next = 1'b0;
                                state_next  = ST_RESP;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (cnt_reg == nbytes - SW'(1))
                    state_next = ST_RESP;
                else
                    cnt_next = cnt_reg + SW'(1);
            end

            ST_RMW:
            begin
                if (op_reg == OP_TEST)
                begin
                    rbit_next = ram_rdata[idx_reg[2:0]];
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(idx_reg[11:3]);
                    ram_wdata = val_reg ? (ram_rdata | mask) : (ram_rdata & ~mask);
                end
                state_next = ST_RESP;
            end

            ST_SCAN:
            begin
                sc_ctl.byte_valid = dv_reg;
                if (sc_stat.hit)
                begin
                    rfound_next = 1'b1;
                    rpos_next   = sc_stat.position;
                    state_next  = ST_RESP;
                end
                else if (cnt_reg == nbytes && !dv_reg)
                begin
                    rfound_next = 1'b0;
                    state_next  = ST_RESP;
                end
                else if (cnt_reg != nbytes)
                begin
                    // stream reads; byte arrives next cycle with dv_reg
                    ram_re   = 1'b1;
                    dv_next  = 1'b1;
                    cnt_next = cnt_reg + SW'(1);
                end
            end

            ST_RESP:
            begin
                if (!ovalid_reg || m_tready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {2'b00, rbit_reg, rpos_reg, rfound_reg};
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            cnt_reg    <= '0;
            dbyte_reg  <= '0;
            dv_reg     <= 1'b0;
            op_reg     <= OP_CLEAR;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            dbyte_reg  <= dbyte_next;
            dv_reg     <= dv_next;
            op_reg     <= op_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        val_reg    <= val_next;
        want_reg   <= want_next;
        rfound_reg <= rfound_next;
        rpos_reg   <= rpos_next;
        rbit_reg   <= rbit_next;
        odata_reg  <= odata_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = ovalid_reg;
    assign m_tdata  = odata_reg;

    bfra_ram #(
        .DEPTH  (MAX_BYTES),
        .ADDR_W (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bfra_run_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (sc_ctl),
        .byte_data (ram_rdata),
        .byte_addr (CFG_W'(dbyte_reg)),
        .want      (want_reg),
        .stat      (sc_stat)
    );

endmodule

// ----- dv/bitmap_alloc_monitor.sv -----
// Bitmap allocator monitor: watches every channel, predicts each result and compares it.
`timescale 1ns / 1ps

module bitmap_alloc_monitor
    import bfra_pkg::*;
#(
    parameter int MAX_BYTES = 512
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    input  logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [31:0]      s_tdata,   // [11:0] bit_index, [12] set_value, [25:13] run_length
    input  logic [1:0]       s_tuser,   // [1:0] op
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [15:0]      m_tdata,   // [0] found, [12:1] position, [13] bit_state
    output int               mismatch_count,
    output int               pending_count
);

    localparam int MAP_AW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] position;
        logic             bit_state;
    } alloc_result_t;

    logic [7:0]    used_map [MAX_BYTES];
    int            managed_bytes;
    alloc_result_t pending_results [$];

    task automatic report_mismatch(string what, int got_v, int expected_v);
        $display("%0t ns MISMATCH %s: got %0d, expected %0d", $time, what, got_v, expected_v);
        mismatch_count++;
    endtask

    // Applies one request to the shadow bitmap and returns the result it should produce.
    function automatic alloc_result_t bitmap_apply(op_t op, logic [IDX_W-1:0] idx,
                                                   logic set_value, logic [RUN_W-1:0] want);
        alloc_result_t res;
        int bit_limit;
        int run;
        int i;
        logic [IDX_W-1:0] bpos;
        bit_limit = managed_bytes * 8;
        res = '0;
        res.found = 1'b1;
        run = 0;
        case (op)
            OP_CLEAR:
            begin
                for (i = 0; i < managed_bytes; i++)
                    used_map[MAP_AW'(i)] = 8'h00;
            end
            OP_TEST:
            begin
                if (idx < bit_limit)
                    res.bit_state = used_map[idx[IDX_W-1:3]][idx[2:0]];
            end
            OP_SET:
            begin
                if (idx < bit_limit)
                    used_map[idx[IDX_W-1:3]][idx[2:0]] = set_value;
            end
            default:
            begin
                // first fit: lowest run of want free bits ending below the limit
                res.found = 1'b0;
                if (want != 0 && want <= bit_limit)
                begin
                    for (i = 0; i < bit_limit && !res.found; i++)
                    begin
                        bpos = IDX_W'(i);
                        if (used_map[bpos[IDX_W-1:3]][bpos[2:0]])
                            run = 0;
                        else
                            run++;
                        if (run == want)
                        begin
                            res.found = 1'b1;
                            res.position = IDX_W'(i + 1 - want);
                        end
                    end
                end
            end
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        alloc_result_t got;
        alloc_result_t expected_res;
        if (!rst_n)
        begin
            foreach (used_map[b])
                used_map[b] = 8'h00;
            managed_bytes = (MAX_BYTES < 512) ? MAX_BYTES : 512;
            pending_results.delete();
            mismatch_count = 0;
            pending_count <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.found = m_tdata[0];
                got.position = m_tdata[12:1];
                got.bit_state = m_tdata[13];
                if (pending_results.size() == 0)
                    report_mismatch("result with nothing pending, position", got.position, -1);
                else
                begin
                    expected_res = pending_results.pop_front();
                    if (got.found != expected_res.found)
                        report_mismatch("found", got.found, expected_res.found);
                    if (got.position != expected_res.position)
                        report_mismatch("position", got.position, expected_res.position);
                    if (got.bit_state != expected_res.bit_state)
                        report_mismatch("bit_state", got.bit_state, expected_res.bit_state);
                end
            end
            if (cfg_valid && cfg_ready)
                managed_bytes = (cfg_data > MAX_BYTES) ? MAX_BYTES : cfg_data;
            if (s_tvalid && s_tready)
                pending_results.push_back(bitmap_apply(op_t'(s_tuser), s_tdata[11:0],
                                                       s_tdata[12], s_tdata[25:13]));
            pending_count <= pending_results.size();
        end
    end

endmodule

// ----- dv/testbench.sv -----
// Testbench top for the bitmap allocator: reset, stimulus phases, watchdog and verdict.
`timescale 1ns / 1ps

module testbench;
    import bfra_pkg::*;

    localparam int MAX_BYTES      = 512;
    localparam int WATCHDOG_LIMIT = 8000;
    localparam int DRAIN_CYCLES   = 600;   // longest scan plus margin

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CFG_W-1:0] cfg_data  = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [31:0]      s_tdata   = '0;   // [11:0] bit_index, [12] set_value, [25:13] run_length
    logic [1:0]       s_tuser   = OP_CLEAR;   // [1:0] op
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [15:0]      m_tdata;   // [0] found, [12:1] position, [13] bit_state

    int mismatch_count;
    int pending_count;

    int snd_idle_pct  = 0;
    int rcv_stall_pct = 0;
    int bit_limit     = MAX_BYTES * 8;   // bits currently managed, shapes the stimulus
    int sent_count    = 0;
    int scan_count    = 0;
    int clear_count   = 0;
    int cfg_writes    = 0;
    int pauses        = 0;
    int quiet_cycles  = 0;

    bitmap_free_run_allocator_top #(
        .MAX_BYTES(MAX_BYTES)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bitmap_alloc_monitor #(
        .MAX_BYTES(MAX_BYTES)
    ) alloc_mon (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .mismatch_count(mismatch_count),
        .pending_count (pending_count)
    );

    always #5 clk = ~clk;

    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= rcv_stall_pct);

    always @(posedge clk)
    begin
        if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("bitmap_free_run_allocator_top verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Called at a falling edge; returns at a falling edge after the transaction.
    task automatic send_req(op_t op, logic [IDX_W-1:0] idx, logic set_value,
                            logic [RUN_W-1:0] run_len);
        while ($urandom_range(99) < snd_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, run_len, set_value, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        sent_count++;
        if (op == OP_SCAN)
            scan_count++;
        if (op == OP_CLEAR)
            clear_count++;
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
    endtask

    task automatic write_bytes_in_use(logic [CFG_W-1:0] value);
        hold_until_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        bit_limit = ((value > MAX_BYTES) ? MAX_BYTES : value) * 8;
        cfg_writes++;
    endtask

    task automatic set_idle(int mode);
        case (mode)
            0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
            1: begin snd_idle_pct = 59; rcv_stall_pct = 0;  end
            2: begin snd_idle_pct = 0;  rcv_stall_pct = 59; end
            default: begin snd_idle_pct = 25; rcv_stall_pct = 25; end
        endcase
    endtask

    function automatic logic [IDX_W-1:0] rand_index();
        if (bit_limit == 0)
            return IDX_W'($urandom_range(4095));
        return IDX_W'($urandom_range(bit_limit - 1));
    endfunction

    function automatic logic [RUN_W-1:0] rand_run();
        return RUN_W'($urandom_range(8191));
    endfunction

    // Mostly short runs that fit; some up to the limit, some beyond it, a few zero.
    function automatic logic [RUN_W-1:0] scan_length();
        int pick;
        pick = $urandom_range(99);
        if (bit_limit == 0 || pick < 5)
            return RUN_W'($urandom_range(8191));
        if (pick < 8)
            return '0;
        if (pick < 70)
            return RUN_W'($urandom_range((bit_limit < 24) ? bit_limit : 24, 1));
        if (pick < 90)
            return RUN_W'($urandom_range(bit_limit, 1));
        return RUN_W'($urandom_range(4096, bit_limit));
    endfunction

    task automatic run_phase(logic [CFG_W-1:0] bytes_cfg, int n_items, int mode);
        int done;
        int pick;
        int span;
        int k;
        logic [IDX_W-1:0] start;
        logic paused;
        write_bytes_in_use(bytes_cfg);
        set_idle(mode);
        done = 0;
        paused = 1'b0;
        while (done < n_items)
        begin
            if (!paused && done >= n_items / 2)
            begin
                hold_until_drained();
                pauses++;
                paused = 1'b1;
            end
            pick = $urandom_range(99);
            if (pick < 30)
            begin
                // claim (mostly) or release a contiguous block
                span = $urandom_range(8, 1);
                start = rand_index();
                for (k = 0; k < span; k++)
                    send_req(OP_SET, IDX_W'(start + k), pick < 21, rand_run());
                done += span;
            end
            else
            begin
                if (pick < 65)
                    send_req(OP_SCAN, IDX_W'($urandom_range(4095)), 1'($urandom_range(1)),
                             scan_length());
                else if (pick < 85)
                    send_req(OP_TEST, rand_index(), 1'($urandom_range(1)), rand_run());
                else if (pick < 95)
                    send_req($urandom_range(1) ? OP_TEST : OP_SET,
                             IDX_W'($urandom_range(4095)), 1'($urandom_range(1)), rand_run());
                else if (pick < 97)
                    send_req(OP_CLEAR, IDX_W'($urandom_range(4095)), 1'($urandom_range(1)),
                             rand_run());
                else
                    send_req(op_t'($urandom_range(3)), IDX_W'($urandom_range(4095)),
                             1'($urandom_range(1)), rand_run());
                done++;
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: full-size map after reset
        set_idle(0);
        send_req(OP_TEST, 12'd0, 1'b0, 13'd0);
        send_req(OP_SET, 12'd0, 1'b1, 13'd0);
        send_req(OP_SET, 12'd4095, 1'b1, 13'd0);
        send_req(OP_TEST, 12'd4095, 1'b0, 13'd0);
        send_req(OP_SCAN, 12'd0, 1'b0, 13'd1);
        send_req(OP_SCAN, 12'd0, 1'b0, 13'd0);
        send_req(OP_SCAN, 12'd0, 1'b0, 13'd4096);
        send_req(OP_SCAN, 12'hfff, 1'b1, 13'h1fff);
        send_req(OP_SET, 12'd0, 1'b0, 13'd0);
        send_req(OP_SET, 12'd4095, 1'b0, 13'd0);
        send_req(OP_SCAN, 12'd0, 1'b0, 13'd4096);
        send_req(OP_SET, 12'd5, 1'b1, 13'd0);
        send_req(OP_SCAN, 12'd0, 1'b0, 13'd5);
        send_req(OP_CLEAR, 12'd0, 1'b0, 13'd0);
        send_req(OP_TEST, 12'd5, 1'b0, 13'd0);
        send_req(OP_SET, 12'd100, 1'b1, 13'd0);

        // two bytes managed: out-of-range index, run bound, clear extent
        write_bytes_in_use(10'd2);
        send_req(OP_SET, 12'd20, 1'b1, 13'd0);
        send_req(OP_TEST, 12'd20, 1'b0, 13'd0);
        send_req(OP_SCAN, 12'd0, 1'b0, 13'd16);
        send_req(OP_SCAN, 12'd0, 1'b0, 13'd17);
        send_req(OP_SET, 12'd15, 1'b1, 13'd0);
        send_req(OP_SCAN, 12'd0, 1'b0, 13'd15);
        send_req(OP_CLEAR, 12'd0, 1'b0, 13'd0);

        // nothing managed: every scan fails
        write_bytes_in_use(10'd0);
        send_req(OP_SCAN, 12'd0, 1'b0, 13'd1);

        // saturating write; bit 100 survived the narrow clear
        write_bytes_in_use(10'h3ff);
        send_req(OP_TEST, 12'd100, 1'b0, 13'd0);
        send_req(OP_TEST, 12'd20, 1'b0, 13'd0);
        send_req(OP_SCAN, 12'd0, 1'b0, 13'd4096);

        run_phase(10'd512, 130, 0);
        run_phase(10'd1, 60, 1);
        run_phase(10'd2, 100, 2);
        run_phase(10'd16, 140, 3);
        run_phase(10'h3ff, 130, 1);
        run_phase(10'd0, 20, 0);
        run_phase(10'd64, 150, 2);
        run_phase(10'd5, 120, 0);
        run_phase(10'd200, 130, 3);
        run_phase(CFG_W'($urandom_range(1023)), 160, $urandom_range(3));

        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d requests (%0d scans, %0d clears) over %0d register writes,",
                 sent_count, scan_count, clear_count, cfg_writes);
        $display("including 0 and saturating sizes, all idle patterns, %0d drain pauses.",
                 pauses);
        if (mismatch_count == 0 && pending_count == 0)
            $display("bitmap_free_run_allocator_top verification clean");
        else
            $display("bitmap_free_run_allocator_top verification failed");
        $finish;
    end

endmodule
